/* rtl/gpp_pkg.sv */
package gpp_pkg;

  // Number of target bits that take part in the search
  localparam int VALUE_WIDTH = 10;

  // Fixed field widths of the ports
  localparam int TARGET_W = 10;
  localparam int SMALL_W  = 9;
  localparam int LARGE_W  = 10;

  // Result cap per target
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // Sieve table: one flag per value below 2**VALUE_WIDTH
  localparam int SIEVE_DEPTH = 1 << VALUE_WIDTH;

  // Every composite below 2**VALUE_WIDTH has a factor no larger than DIV_MAX
  localparam int DIV_W   = (VALUE_WIDTH + 1) / 2;
  localparam int DIV_MAX = (1 << DIV_W) - 1;

  localparam int FIRST_DIV   = 2;
  localparam int FIRST_SPLIT = 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_SIEVE,
    ST_IDLE,
    ST_CHECK,
    ST_EVAL,
    ST_FLUSH
  } gpp_state_e;

  typedef struct packed {
    logic clr_step;
    logic sieve_step;
    logic load;
    logic eval;
    logic flush;
  } gpp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sieve_last;
    logic scan_done;
    logic full_hit;
  } gpp_sts_t;

endpackage

/* rtl/gpp_ram.sv */
module gpp_ram #(
  parameter int Width = 1,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gpp_dpath.sv */
module gpp_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gpp_pkg::gpp_cmd_t              cmd_i,
  output gpp_pkg::gpp_sts_t              sts_o,
  input  logic [gpp_pkg::TARGET_W-1:0]   target_sum_i,
  output logic                           valid_o,
  output logic                           found_o,
  output logic [gpp_pkg::SMALL_W-1:0]    smaller_prime_o,
  output logic [gpp_pkg::LARGE_W-1:0]    larger_prime_o,
  output logic                           last_o
);

  import gpp_pkg::*;

  localparam int AW = VALUE_WIDTH;

  // sieve build
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [DIV_W-1:0] p_q, p_d;
  logic [DIV_W-1:0] p_inc;
  logic [AW:0]      cnt_sum;

  // split walk
  logic [AW-1:0]    n_q;
  logic [AW-1:0]    i_q;
  logic [AW-2:0]    pend_q;
  logic             pend_v_q;
  logic [CNT_W-1:0] count_q;

  // sieve access
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] raddr_b;
  logic          prime_a;
  logic          prime_b;
  logic          hit;

  // result register
  logic               valid_q, valid_d;
  logic               found_q, found_d;
  logic [SMALL_W-1:0] small_q, small_d;
  logic [LARGE_W-1:0] large_q, large_d;
  logic               last_q, last_d;

  assign cnt_sum = {1'b0, cnt_q} + (AW+1)'(p_q);
  assign p_inc   = p_q + 1'b1;

  assign sts_o.clr_last   = (cnt_q == AW'(SIEVE_DEPTH - 1));
  assign sts_o.sieve_last = cnt_sum[AW] && (p_q == DIV_W'(DIV_MAX));
  assign sts_o.scan_done  = (i_q > {1'b0, n_q[AW-1:1]});
  assign sts_o.full_hit   = hit && (count_q == CNT_W'(MAX_RESULTS - 1));

  always_comb begin
    cnt_d = cnt_q;
    p_d   = p_q;
    if (cmd_i.clr_step) begin
      if (sts_o.clr_last) begin
        cnt_d = AW'(2 * FIRST_DIV);
        p_d   = DIV_W'(FIRST_DIV);
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (cmd_i.sieve_step) begin
      if (cnt_sum[AW]) begin
        p_d   = p_inc;
        cnt_d = AW'({p_inc, 1'b0});
      end else begin
        cnt_d = cnt_sum[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      p_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      p_q   <= p_d;
    end
  end

  // clear pass writes ones, the sieve strikes out multiples
  assign ram_we    = cmd_i.clr_step | cmd_i.sieve_step;
  assign ram_waddr = cnt_q;
  assign ram_wdata = cmd_i.clr_step;
  assign raddr_b   = n_q - i_q;

  gpp_ram #(
    .Width (1),
    .Depth (SIEVE_DEPTH)
  ) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (i_q),
    .rdata_o (prime_a)
  );

  gpp_ram #(
    .Width (1),
    .Depth (SIEVE_DEPTH)
  ) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_b),
    .rdata_o (prime_b)
  );

  assign hit = prime_a & prime_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      count_q  <= '0;
    end else if (cmd_i.load) begin
      pend_v_q <= 1'b0;
      count_q  <= '0;
    end else if (cmd_i.eval && hit) begin
      pend_v_q <= 1'b1;
      count_q  <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= target_sum_i[AW-1:0];
      i_q <= AW'(FIRST_SPLIT);
    end else if (cmd_i.eval) begin
      i_q <= i_q + 1'b1;
      if (hit) begin
        pend_q <= i_q[AW-2:0];
      end
    end
  end

  // Hold one pair back so that the final one can carry last
  always_comb begin
    valid_d = (cmd_i.eval && hit && pend_v_q) || cmd_i.flush;
    found_d = pend_v_q;
    last_d  = cmd_i.flush;
    small_d = pend_v_q ? SMALL_W'(pend_q) : '0;
    large_d = pend_v_q ? LARGE_W'(n_q - AW'(pend_q)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      found_q <= found_d;
      small_q <= small_d;
      large_q <= large_d;
      last_q  <= last_d;
    end
  end

  assign valid_o         = valid_q;
  assign found_o         = found_q;
  assign smaller_prime_o = small_q;
  assign larger_prime_o  = large_q;
  assign last_o          = last_q;

endmodule

/* rtl/gpp_ctrl.sv */
module gpp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  gpp_pkg::gpp_sts_t sts_i,
  output gpp_pkg::gpp_cmd_t cmd_o,
  output logic              busy_o
);

  import gpp_pkg::*;

  gpp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_SIEVE;
        end
      end
      ST_SIEVE: begin
        cmd_o.sieve_step = 1'b1;
        if (sts_i.sieve_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // sieve read is in flight for the current split
        state_d = sts_i.scan_done ? ST_FLUSH : ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.full_hit ? ST_FLUSH : ST_CHECK;
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/goldbach_prime_pair_finder.sv */
// Goldbach pair finder. Pulse start_i while busy_o is low to hand in one
// target; the low VALUE_WIDTH bits of target_sum_i are used. The block then
// walks every split i = 2 .. n/2 and, for each split where both i and n-i
// are prime, presents one item on the result ports for a single cycle with
// valid_o high, in increasing order of i; the final item of the target has
// last_o set. At most 64 items are produced per target. When no split
// qualifies, a single item with found_o low, both primes zero and last_o
// high is produced. The receiver cannot stall: sample every cycle in which
// valid_o is high. Primality comes from a sieve table built once after
// reset: a clearing pass followed by striking out multiples, with busy_o
// high throughout. After that each split goes through a sieve read, then
// an evaluate step; a completed walk ends with a closing read and a flush,
// and reaching 64 pairs ends the walk early, straight into the flush.
// busy_o stays high after a start until the flush is done, so the block
// takes no new target before it is through with the last one. A new target
// may be started in the cycle that carries the last item of the previous
// one.
module goldbach_prime_pair_finder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gpp_pkg::TARGET_W-1:0] target_sum_i,
  output logic                         busy_o,
  output logic                         valid_o,
  output logic                         found_o,
  output logic [gpp_pkg::SMALL_W-1:0]  smaller_prime_o,
  output logic [gpp_pkg::LARGE_W-1:0]  larger_prime_o,
  output logic                         last_o
);

  import gpp_pkg::*;

  gpp_cmd_t cmd;
  gpp_sts_t sts;

  // Sequence the sieve build and the split walk
  gpp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Hold the sieve, the walk counters and the result register
  gpp_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .target_sum_i    (target_sum_i),
    .valid_o         (valid_o),
    .found_o         (found_o),
    .smaller_prime_o (smaller_prime_o),
    .larger_prime_o  (larger_prime_o),
    .last_o          (last_o)
  );

  // The final item of a target always leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy_o)
    else $error("last item emitted while still busy");

  // An empty result carries zeros and closes the target
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !found_o |-> last_o && (smaller_prime_o == '0) && (larger_prime_o == '0))
    else $error("malformed empty result");

  // Pairs are ordered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && found_o |-> (LARGE_W'(smaller_prime_o) <= larger_prime_o))
    else $error("smaller prime exceeds larger prime");

  // Work only begins on a start request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy raised without a start");

endmodule

/* dv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpp_pkg::*;

  // Cycles with neither an accepted target nor a result before giving up.
  // Covers the sieve build after reset and the longest split walk with room.
  localparam int unsigned STALL_LIMIT = 20000;
  // Quiet cycles after the final result to catch stray items
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RAND_ITEMS = 320;
  localparam int unsigned SHOWN_ERRORS = 10;
  localparam int unsigned NUM_ROWS = 24;

  // One pair as it should appear on the result ports
  typedef struct packed {
    logic               found;
    logic [SMALL_W-1:0] small_p;
    logic [LARGE_W-1:0] large_p;
    logic               last;
  } pair_t;

  // Directed row: a target, plus a single typed result where it is obvious
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic                known;
    logic                found;
    logic [SMALL_W-1:0]  small_p;
    logic [LARGE_W-1:0]  large_p;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic [TARGET_W-1:0] target_sum_i;
  logic                busy_o;
  logic                valid_o;
  logic                found_o;
  logic [SMALL_W-1:0]  smaller_prime_o;
  logic [LARGE_W-1:0]  larger_prime_o;
  logic                last_o;

  pair_t       pending_pairs[$];
  int unsigned fail_cnt;
  int unsigned targets_sent;
  int unsigned pairs_seen;
  int unsigned empty_seen;
  int unsigned most_pairs;
  int unsigned idle_cycles;

  // Odd targets whose only candidate split is 2 give one readable pair;
  // the rest are worked out by the predictor.
  dir_row_t dir_rows [NUM_ROWS] = '{
    '{10'd0,    1'b1, 1'b0, 9'd0,   10'd0},     // no split at all
    '{10'd1,    1'b1, 1'b0, 9'd0,   10'd0},
    '{10'd2,    1'b1, 1'b0, 9'd0,   10'd0},
    '{10'd3,    1'b1, 1'b0, 9'd0,   10'd0},
    '{10'd4,    1'b1, 1'b1, 9'd2,   10'd2},     // smallest target with a pair
    '{10'd5,    1'b1, 1'b1, 9'd2,   10'd3},
    '{10'd6,    1'b1, 1'b1, 9'd3,   10'd3},
    '{10'd7,    1'b1, 1'b1, 9'd2,   10'd5},
    '{10'd9,    1'b1, 1'b1, 9'd2,   10'd7},
    '{10'd11,   1'b1, 1'b0, 9'd0,   10'd0},     // odd, n-2 composite
    '{10'd27,   1'b1, 1'b0, 9'd0,   10'd0},
    '{10'd1023, 1'b1, 1'b1, 9'd2,   10'd1021},  // all target bits set
    '{10'd1021, 1'b1, 1'b1, 9'd2,   10'd1019},
    '{10'd1017, 1'b1, 1'b0, 9'd0,   10'd0},
    '{10'd511,  1'b1, 1'b1, 9'd2,   10'd509},
    '{10'd513,  1'b1, 1'b0, 9'd0,   10'd0},
    '{10'd512,  1'b0, 1'b0, 9'd0,   10'd0},     // top bit alone
    '{10'd1022, 1'b0, 1'b0, 9'd0,   10'd0},
    '{10'd1020, 1'b0, 1'b0, 9'd0,   10'd0},
    '{10'd1000, 1'b0, 1'b0, 9'd0,   10'd0},
    '{10'd990,  1'b0, 1'b0, 9'd0,   10'd0},     // many pairs
    '{10'd8,    1'b0, 1'b0, 9'd0,   10'd0},
    '{10'd100,  1'b0, 1'b0, 9'd0,   10'd0},
    '{10'd210,  1'b0, 1'b0, 9'd0,   10'd0}
  };

  goldbach_prime_pair_finder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .target_sum_i    (target_sum_i),
    .busy_o          (busy_o),
    .valid_o         (valid_o),
    .found_o         (found_o),
    .smaller_prime_o (smaller_prime_o),
    .larger_prime_o  (larger_prime_o),
    .last_o          (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Trial division with divisors 2 .. v/2
  function automatic bit is_prime_trial(int unsigned v);
    int unsigned d;
    for (d = 2; d <= v / 2; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue every pair the block owes for target t, capped per target
  function automatic void predict_pairs(logic [TARGET_W-1:0] t);
    int unsigned n;
    int unsigned i;
    int unsigned cnt;
    pair_t       p;
    n   = int'(t) & ((1 << VALUE_WIDTH) - 1);
    cnt = 0;
    for (i = FIRST_SPLIT; i <= n / 2 && cnt < MAX_RESULTS; i++) begin
      if (is_prime_trial(i) && is_prime_trial(n - i)) begin
        p.found   = 1'b1;
        p.small_p = i[SMALL_W-1:0];
        p.large_p = LARGE_W'(n - i);
        p.last    = 1'b0;
        pending_pairs.push_back(p);
        cnt++;
      end
    end
    if (cnt == 0) begin
      p = '{found: 1'b0, small_p: '0, large_p: '0, last: 1'b1};
      pending_pairs.push_back(p);
    end else begin
      pending_pairs[pending_pairs.size() - 1].last = 1'b1;
    end
    if (cnt > most_pairs) most_pairs = cnt;
  endfunction

  function automatic void flag_error(string msg);
    fail_cnt++;
    if (fail_cnt <= SHOWN_ERRORS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Present one target from the next falling edge and hold it until the
  // block takes it; return just after the accepting rising edge.
  task automatic offer_target(input logic [TARGET_W-1:0] t, input bit known,
                              input pair_t typed_pair);
    @(negedge clk_i);
    start_i      <= 1'b1;
    target_sum_i <= t;
    do @(posedge clk_i); while (busy_o);
    // busy_o was sampled before this edge updated it, so the item is taken
    if (known) pending_pairs.push_back(typed_pair);
    else predict_pairs(t);
    targets_sent++;
  endtask

  // Drop start and hold it low for a number of cycles
  task automatic hold_idle(input int unsigned cycles);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Mix of full-range targets with small, even and near-top ones
  function automatic logic [TARGET_W-1:0] pick_target();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      6: begin
        return TARGET_W'($urandom_range(0, 15));
      end
      7: begin
        return TARGET_W'($urandom_range(2, 511) * 2);
      end
      8: begin
        return TARGET_W'($urandom_range(960, 1023));
      end
      default: begin
        return TARGET_W'($urandom_range(0, 1023));
      end
    endcase
  endfunction

  // Check each result against the oldest expectation, and watch for a hang
  always @(posedge clk_i) begin
    pair_t exp_p;
    if (rst_ni && valid_o) begin
      if (pending_pairs.size() == 0) begin
        flag_error($sformatf("unexpected item found=%0b small=%0d large=%0d last=%0b",
                             found_o, smaller_prime_o, larger_prime_o, last_o));
      end else begin
        exp_p = pending_pairs.pop_front();
        if (found_o !== exp_p.found || smaller_prime_o !== exp_p.small_p ||
            larger_prime_o !== exp_p.large_p || last_o !== exp_p.last) begin
          flag_error($sformatf({"mismatch exp found=%0b small=%0d large=%0d last=%0b",
                                " got found=%0b small=%0d large=%0d last=%0b"},
                               exp_p.found, exp_p.small_p, exp_p.large_p, exp_p.last,
                               found_o, smaller_prime_o, larger_prime_o, last_o));
        end
      end
      pairs_seen++;
      if (!found_o) empty_seen++;
    end
    if ((start_i && !busy_o) || valid_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    pair_t       typed_pair;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    target_sum_i = '0;
    fail_cnt     = 0;
    targets_sent = 0;
    pairs_seen   = 0;
    empty_seen   = 0;
    most_pairs   = 0;
    idle_cycles  = 0;

    // Hold reset, then release it away from the rising edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows back to back; the sieve build keeps busy high at first
    foreach (dir_rows[r]) begin
      typed_pair = '{found: dir_rows[r].found, small_p: dir_rows[r].small_p,
                     large_p: dir_rows[r].large_p, last: 1'b1};
      offer_target(dir_rows[r].target, dir_rows[r].known, typed_pair);
    end

    // Let the block drain completely before the random part
    hold_idle(0);
    while (pending_pairs.size() != 0) @(posedge clk_i);

    // Random part: an unbroken stretch first, then bursts with gaps
    sent = 0;
    while (sent < RAND_ITEMS) begin
      burst = (sent < 40) ? 40 : $urandom_range(1, 8);
      repeat (burst) begin
        if (sent < RAND_ITEMS) begin
          offer_target(pick_target(), 1'b0, '0);
          sent++;
          // Halfway through, wait out every outstanding result once more
          if (sent == RAND_ITEMS / 2) begin
            hold_idle(0);
            while (pending_pairs.size() != 0) @(posedge clk_i);
          end
        end
      end
      if (sent >= 40 && $urandom_range(0, 3) != 0) hold_idle($urandom_range(0, 30));
    end

    // Drain, then give stray items a chance to show up
    hold_idle(0);
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d targets and %0d result items, %0d of them with no pair.",
             targets_sent, pairs_seen, empty_seen);
    $display("Largest pair count for one target: %0d; failures: %0d.",
             most_pairs, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
